/* sv/buddy_block_allocator_macros.svh */
// Assertion helpers used by the allocator datapath.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bba_pkg.sv */
package bba_pkg;

    // Pool geometry
    localparam int MIN_BLOCK_BYTES = 256;
    localparam int MAX_ORDER       = 10;
    localparam int UNIT_SHIFT      = 8;
    localparam int POOL_BYTES      = 262144;

    // Field widths
    localparam int OFF_W   = 10;
    localparam int ORD_W   = 4;
    localparam int SIZE_W  = 19;
    localparam int ALIGN_W = 17;
    localparam int ABYTE_W = OFF_W + UNIT_SHIFT;
    localparam int USED_W  = 19;
    localparam int NEED_W  = 20;

    // Free map storage: one region of 32-bit words per order
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int MEM_DEPTH = 68;
    localparam int ADDR_W    = 7;

    // Remainder unit
    localparam int DIV_STEPS = ABYTE_W;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_TAKE_WR,
        ST_SPLIT_STEP,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_ALIGN,
        ST_DIV_WAIT,
        ST_OUT_ALLOC,
        ST_OUT_FAIL,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_BUD_RD,
        ST_BUD_CHK,
        ST_MERGE_UP,
        ST_MERGE_CHK,
        ST_SET_RD,
        ST_SET_WR,
        ST_OUT_FREE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_SCAN_INIT,
        DP_FREE_INIT,
        DP_READ,
        DP_FOUND,
        DP_NEXT,
        DP_WR_CLR,
        DP_WR_SET,
        DP_SPLIT,
        DP_BUDDY,
        DP_MERGE_UP,
        DP_DIV_START,
        DP_OUT_ALLOC,
        DP_OUT_FREE,
        DP_OUT_FAIL
    } dp_op_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic too_big;
        logic bad_free;
        logic hit;
        logic last_word;
        logic k_top;
        logic k_gt_ord;
        logic bit_set;
        logic div_need;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // First word of each order's region
    function automatic logic [ADDR_W-1:0] word_base(input logic [ORD_W-1:0] k);
        logic [ADDR_W-1:0] b;
        unique case (k)
            4'd0:    b = 7'd0;
            4'd1:    b = 7'd32;
            4'd2:    b = 7'd48;
            4'd3:    b = 7'd56;
            4'd4:    b = 7'd60;
            4'd5:    b = 7'd62;
            4'd6:    b = 7'd63;
            4'd7:    b = 7'd64;
            4'd8:    b = 7'd65;
            4'd9:    b = 7'd66;
            4'd10:   b = 7'd67;
            default: b = 7'd0;
        endcase
        return b;
    endfunction

    // Index of the last word within an order's region
    function automatic logic [BIT_W-1:0] last_word_idx(input logic [ORD_W-1:0] k);
        logic [BIT_W-1:0] w;
        unique case (k)
            4'd0:    w = 5'd31;
            4'd1:    w = 5'd15;
            4'd2:    w = 5'd7;
            4'd3:    w = 5'd3;
            4'd4:    w = 5'd1;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

    // Bits of a word that hold real blocks for an order
    function automatic logic [WORD_W-1:0] order_mask(input logic [ORD_W-1:0] k);
        logic [WORD_W-1:0] m;
        unique case (k)
            4'd6:    m = 32'h0000_FFFF;
            4'd7:    m = 32'h0000_00FF;
            4'd8:    m = 32'h0000_000F;
            4'd9:    m = 32'h0000_0003;
            4'd10:   m = 32'h0000_0001;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

/* sv/bba_rem_unit.sv */
module bba_rem_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bba_pkg::ABYTE_W-1:0]  dividend,
    input  logic [bba_pkg::ALIGN_W-1:0]  divisor,
    output logic                         busy,
    output logic [bba_pkg::ALIGN_W-1:0]  rem
);
    import bba_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [ALIGN_W-1:0]   rem_reg, rem_next;
    logic [ABYTE_W-1:0]   dvd_reg, dvd_next;
    logic [ALIGN_W-1:0]   div_reg, div_next;
    logic [ALIGN_W:0]     trial;

    // One restoring step per cycle, remainder only
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        trial     = {rem_reg, dvd_reg[ABYTE_W-1]};
        if (start)
        begin
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = ALIGN_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[ALIGN_W-1:0];
            dvd_next = {dvd_reg[ABYTE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

/* sv/bba_datapath.sv */
`include "buddy_block_allocator_macros.svh"

module bba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bba_pkg::dp_op_t               op,
    output bba_pkg::dp_status_t           status,
    input  logic                          mode,
    input  logic [bba_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [bba_pkg::ALIGN_W-1:0]   alignment_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     free_offset_units,
    input  logic [bba_pkg::ORD_W-1:0]     free_order,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [bba_pkg::OFF_W-1:0]     block_offset_units,
    output logic [bba_pkg::ORD_W-1:0]     block_order,
    output logic [bba_pkg::ABYTE_W-1:0]   aligned_byte_offset,
    output logic [bba_pkg::USED_W-1:0]    used_bytes
);
    import bba_pkg::*;

    // Free map words
    logic [WORD_W-1:0] mem [MEM_DEPTH];
    logic [WORD_W-1:0] rd_reg;

    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic               mode_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [OFF_W-1:0]   foff_reg;
    logic [ORD_W-1:0]   ford_reg;
    logic [ORD_W-1:0]   k_reg, req_ord_reg;
    logic [OFF_W-1:0]   pos_reg, off_reg;
    logic [USED_W-1:0]  used_reg;

    logic               out_valid_reg;
    logic               ok_reg;
    logic [OFF_W-1:0]   boff_reg;
    logic [ORD_W-1:0]   bord_reg;
    logic [ABYTE_W-1:0] aligned_reg;
    logic [USED_W-1:0]  uout_reg;

    // Request decode at accept
    logic               in_pow2, add_align;
    logic [NEED_W-1:0]  need_in;

    always_comb
    begin
        in_pow2   = ((alignment_bytes & (alignment_bytes - 1'b1)) == '0);
        add_align = (alignment_bytes != '0) &&
                    !(in_pow2 && (alignment_bytes <= ALIGN_W'(MIN_BLOCK_BYTES)));
        need_in   = NEED_W'(size_bytes) + (add_align ? NEED_W'(alignment_bytes) : '0);
    end

    // Order needed by the held request
    logic [NEED_W:0]    need_rnd;
    logic [OFF_W:0]     units;
    logic [OFF_W-1:0]   units_m1;
    logic [ORD_W-1:0]   req_ord;

    always_comb
    begin
        need_rnd = {1'b0, need_reg} + (NEED_W+1)'(MIN_BLOCK_BYTES - 1);
        units    = need_rnd[UNIT_SHIFT +: OFF_W+1];
        units_m1 = (units == '0) ? '0 : OFF_W'(units - 1'b1);
        req_ord  = '0;
        for (int i = 0; i < OFF_W; i++)
            if (units_m1[i])
                req_ord = ORD_W'(i + 1);
    end

    // Free request checks
    logic bad_low;

    always_comb
    begin
        bad_low = 1'b0;
        for (int i = 0; i < OFF_W; i++)
            if ((ORD_W'(i) < ford_reg) && foff_reg[i])
                bad_low = 1'b1;
    end

    // Cursor into the free map
    logic [ADDR_W-1:0] cur_addr;
    logic [WORD_W-1:0] masked;
    logic [BIT_W-1:0]  ffs;
    logic [OFF_W-1:0]  found_pos;
    logic [ORD_W-1:0]  k_dn;

    always_comb
    begin
        cur_addr  = word_base(k_reg) + ADDR_W'(pos_reg[OFF_W-1:BIT_W]);
        masked    = rd_reg & order_mask(k_reg);
        ffs       = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
            if (masked[i])
                ffs = BIT_W'(i);
        found_pos = {pos_reg[OFF_W-1:BIT_W], ffs};
        k_dn      = k_reg - 1'b1;
    end

    // Memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;

    always_comb
    begin
        mem_we    = (op == DP_CLR) || (op == DP_WR_CLR) || (op == DP_WR_SET);
        mem_addr  = (op == DP_CLR) ? clr_cnt_reg : cur_addr;
        mem_wdata = rd_reg;
        mem_wdata[pos_reg[BIT_W-1:0]] = (op == DP_WR_SET);
        if (op == DP_CLR)
            mem_wdata = (clr_cnt_reg == word_base(ORD_W'(MAX_ORDER))) ? WORD_W'(1) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (op == DP_READ)
            rd_reg <= mem[cur_addr];
    end

    // Alignment and byte count
    logic [ABYTE_W-1:0] byte_off;
    logic               a_pow2, div_need, div_busy;
    logic [ALIGN_W-1:0] div_rem, rem_sel;
    logic [NEED_W-1:0]  aligned_sum;
    logic [USED_W-1:0]  alloc_bytes, free_bytes, used_alloc, used_free;
    logic [USED_W:0]    used_sum;

    always_comb
    begin
        byte_off    = {off_reg, {UNIT_SHIFT{1'b0}}};
        a_pow2      = ((align_reg & (align_reg - 1'b1)) == '0);
        div_need    = (align_reg != '0) && !a_pow2;
        if (div_need)
            rem_sel = div_rem;
        else if (align_reg == '0)
            rem_sel = '0;
        else
            rem_sel = ALIGN_W'(byte_off) & (align_reg - 1'b1);
        aligned_sum = NEED_W'(byte_off) - NEED_W'(rem_sel) + NEED_W'(align_reg);
        alloc_bytes = USED_W'(MIN_BLOCK_BYTES) << k_reg;
        free_bytes  = USED_W'(MIN_BLOCK_BYTES) << ford_reg;
        used_sum    = {1'b0, used_reg} + {1'b0, alloc_bytes};
        used_alloc  = (used_sum > (USED_W+1)'(POOL_BYTES)) ? USED_W'(POOL_BYTES)
                                                           : used_sum[USED_W-1:0];
        used_free   = (used_reg > free_bytes) ? (used_reg - free_bytes) : '0;
    end

    bba_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == DP_DIV_START),
        .dividend (byte_off),
        .divisor  (align_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == DP_CLR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (op == DP_OUT_ALLOC)
                used_reg <= used_alloc;
            else if (op == DP_OUT_FREE)
                used_reg <= used_free;
            if ((op == DP_OUT_ALLOC) || (op == DP_OUT_FREE) || (op == DP_OUT_FAIL))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request, cursor and result words
    always_ff @(posedge clk)
    begin
        unique case (op)
            DP_LOAD:
            begin
                mode_reg  <= mode;
                need_reg  <= need_in;
                align_reg <= alignment_bytes;
                foff_reg  <= free_offset_units;
                ford_reg  <= free_order;
            end
            DP_SCAN_INIT:
            begin
                k_reg       <= req_ord;
                req_ord_reg <= req_ord;
                pos_reg     <= '0;
            end
            DP_FREE_INIT:
            begin
                k_reg   <= ford_reg;
                pos_reg <= foff_reg >> ford_reg;
            end
            DP_FOUND:
            begin
                pos_reg <= found_pos;
                off_reg <= found_pos << k_reg;
            end
            DP_NEXT:
            begin
                if (pos_reg[OFF_W-1:BIT_W] == last_word_idx(k_reg))
                begin
                    k_reg   <= k_reg + 1'b1;
                    pos_reg <= '0;
                end
                else
                    pos_reg <= pos_reg + OFF_W'(WORD_W);
            end
            DP_SPLIT:
            begin
                k_reg   <= k_dn;
                pos_reg <= (off_reg >> k_dn) + 1'b1;
            end
            DP_BUDDY:
                pos_reg[0] <= ~pos_reg[0];
            DP_MERGE_UP:
            begin
                k_reg   <= k_reg + 1'b1;
                pos_reg <= pos_reg >> 1;
            end
            DP_OUT_ALLOC:
            begin
                ok_reg      <= 1'b1;
                boff_reg    <= off_reg;
                bord_reg    <= k_reg;
                aligned_reg <= (rem_sel == '0) ? byte_off : aligned_sum[ABYTE_W-1:0];
                uout_reg    <= used_alloc;
            end
            DP_OUT_FREE:
            begin
                ok_reg      <= 1'b1;
                boff_reg    <= '0;
                bord_reg    <= '0;
                aligned_reg <= '0;
                uout_reg    <= used_free;
            end
            DP_OUT_FAIL:
            begin
                ok_reg      <= 1'b0;
                boff_reg    <= '0;
                bord_reg    <= '0;
                aligned_reg <= '0;
                uout_reg    <= used_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Status back to the controller
    always_comb
    begin
        status.clear_last = (clr_cnt_reg == ADDR_W'(MEM_DEPTH - 1));
        status.is_free    = mode_reg;
        status.too_big    = (need_reg > NEED_W'(POOL_BYTES));
        status.bad_free   = (ford_reg > ORD_W'(MAX_ORDER)) || bad_low;
        status.hit        = (masked != '0);
        status.last_word  = (pos_reg[OFF_W-1:BIT_W] == last_word_idx(k_reg));
        status.k_top      = (k_reg == ORD_W'(MAX_ORDER));
        status.k_gt_ord   = (k_reg > req_ord_reg);
        status.bit_set    = rd_reg[pos_reg[BIT_W-1:0]];
        status.div_need   = div_need;
        status.div_busy   = div_busy;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid           = out_valid_reg;
    assign ok                  = ok_reg;
    assign block_offset_units  = boff_reg;
    assign block_order         = bord_reg;
    assign aligned_byte_offset = aligned_reg;
    assign used_bytes          = uout_reg;

    // Checks
    `BBA_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= USED_W'(POOL_BYTES), "used count above pool")
    `BBA_ASSERT_NOW(a_order_bound, (op == DP_READ), k_reg <= ORD_W'(MAX_ORDER), "cursor order out of range")
    `BBA_ASSERT_NOW(a_out_slot, ((op == DP_OUT_ALLOC) || (op == DP_OUT_FREE) || (op == DP_OUT_FAIL)), (!out_valid_reg || out_ready), "result overwrites untaken word")
    `BBA_ASSERT_NEXT(a_out_set, ((op == DP_OUT_ALLOC) || (op == DP_OUT_FREE) || (op == DP_OUT_FAIL)), out_valid_reg, "result not presented")

endmodule

/* sv/bba_ctrl.sv */
module bba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bba_pkg::dp_status_t  status,
    output bba_pkg::dp_op_t      op
);
    import bba_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Sequencing of free map walks
    always_comb
    begin
        state_next = state_reg;
        op         = DP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                op = DP_CLR;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = DP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_free)
                begin
                    if (status.bad_free)
                        state_next = ST_OUT_FAIL;
                    else
                    begin
                        op         = DP_FREE_INIT;
                        state_next = ST_FREE_RD;
                    end
                end
                else if (status.too_big)
                    state_next = ST_OUT_FAIL;
                else
                begin
                    op         = DP_SCAN_INIT;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                op         = DP_READ;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (status.hit)
                begin
                    op         = DP_FOUND;
                    state_next = ST_TAKE_WR;
                end
                else if (status.last_word && status.k_top)
                    state_next = ST_OUT_FAIL;
                else
                begin
                    op         = DP_NEXT;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_TAKE_WR:
            begin
                op         = DP_WR_CLR;
                state_next = status.k_gt_ord ? ST_SPLIT_STEP : ST_ALIGN;
            end
            ST_SPLIT_STEP:
            begin
                op         = DP_SPLIT;
                state_next = ST_SPLIT_RD;
            end
            ST_SPLIT_RD:
            begin
                op         = DP_READ;
                state_next = ST_SPLIT_WR;
            end
            ST_SPLIT_WR:
            begin
                op         = DP_WR_SET;
                state_next = status.k_gt_ord ? ST_SPLIT_STEP : ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (status.div_need)
                begin
                    op         = DP_DIV_START;
                    state_next = ST_DIV_WAIT;
                end
                else
                    state_next = ST_OUT_ALLOC;
            end
            ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                    state_next = ST_OUT_ALLOC;
            end
            ST_OUT_ALLOC:
            begin
                if (status.out_free)
                begin
                    op         = DP_OUT_ALLOC;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT_FAIL:
            begin
                if (status.out_free)
                begin
                    op         = DP_OUT_FAIL;
                    state_next = ST_IDLE;
                end
            end
            ST_FREE_RD:
            begin
                op         = DP_READ;
                state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK:
            begin
                if (status.bit_set)
                    state_next = ST_OUT_FAIL;
                else if (status.k_top)
                    state_next = ST_SET_WR;
                else
                begin
                    op         = DP_BUDDY;
                    state_next = ST_BUD_RD;
                end
            end
            ST_BUD_RD:
            begin
                op         = DP_READ;
                state_next = ST_BUD_CHK;
            end
            ST_BUD_CHK:
            begin
                if (status.bit_set)
                begin
                    op         = DP_WR_CLR;
                    state_next = ST_MERGE_UP;
                end
                else
                begin
                    op         = DP_BUDDY;
                    state_next = ST_SET_RD;
                end
            end
            ST_MERGE_UP:
            begin
                op         = DP_MERGE_UP;
                state_next = ST_MERGE_CHK;
            end
            ST_MERGE_CHK:
            begin
                if (status.k_top)
                    state_next = ST_SET_RD;
                else
                begin
                    op         = DP_BUDDY;
                    state_next = ST_BUD_RD;
                end
            end
            ST_SET_RD:
            begin
                op         = DP_READ;
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                op         = DP_WR_SET;
                state_next = ST_OUT_FREE;
            end
            ST_OUT_FREE:
            begin
                if (status.out_free)
                begin
                    op         = DP_OUT_FREE;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* sv/buddy_block_allocator.sv */
// Buddy allocator over 1024 units of 256 bytes.
// Input channel (in_valid/in_ready) takes one request word: mode 0 allocates
// size_bytes with alignment_bytes, mode 1 frees free_offset_units/free_order.
// Output channel (out_valid/out_ready) returns one result word per request:
// ok, block offset and order, aligned byte offset and the used byte count.
// One request is in work at a time; a new one is taken while the previous
// result still waits in the output register.
// An allocation scans free map words (up to 68) from the requested order
// upward, then splits one level at a time, and runs the bit-serial remainder
// unit when the alignment is not a power of two; a free checks the block and
// merges with its buddy one level at a time.
// Each walk is bounded by the single-port free map memory, one read or write
// per cycle.
// After reset a clearing pass writes all 68 free map words (only the whole
// pool free); no request is taken until it ends.
// When the receiver stalls, the finished result waits before the output
// register and the controller holds; nothing is dropped.
module buddy_block_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [bba_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [bba_pkg::ALIGN_W-1:0]   alignment_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     free_offset_units,
    input  logic [bba_pkg::ORD_W-1:0]     free_order,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [bba_pkg::OFF_W-1:0]     block_offset_units,
    output logic [bba_pkg::ORD_W-1:0]     block_order,
    output logic [bba_pkg::ABYTE_W-1:0]   aligned_byte_offset,
    output logic [bba_pkg::USED_W-1:0]    used_bytes
);
    import bba_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    bba_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .op                  (op),
        .status              (status),
        .mode                (mode),
        .size_bytes          (size_bytes),
        .alignment_bytes     (alignment_bytes),
        .free_offset_units   (free_offset_units),
        .free_order          (free_order),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .ok                  (ok),
        .block_offset_units  (block_offset_units),
        .block_order         (block_order),
        .aligned_byte_offset (aligned_byte_offset),
        .used_bytes          (used_bytes)
    );

endmodule
